FILE: hw/rtl/dds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

	// field widths
	localparam int VALUE_W = 32;
	localparam int DIGIT_W = 4;
	localparam int POS_W = 4;

	// decimal positions a non-negative 32-bit value can have
	localparam int NUM_POS = 10;

	// wide enough for nine times the largest power of ten
	localparam int THR_W = 34;

	localparam int DEFAULT_MAX_DIGITS = 10;

	// powers of ten, one per decimal position
	localparam logic [THR_W-1:0] POW10 [0:NUM_POS-1] = '{
		34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
		34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
	};

	// commands from the controller
	typedef struct packed {
		logic load;
		logic step;
	} dds_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic done;
		logic out_free;
	} dds_stat_t;

	// digit limit kept within 1..19
	function automatic int lim_of(input int m);
		int r;
		r = m;
		if (r < 1)
			r = 1;
		if (r > 19)
			r = 19;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/decimal_digit_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[31:0] = value (signed)
// m_       out  m_tvalid/m_tready  m_tdata = digit, position; m_tlast = last;
//                                  m_tuser = negative_error
//
// an item is loaded, then takes ten steps of the digit unit,
// one decimal position per step from the highest down, each a compare of the
// value against the nine multiples of that power of ten and a subtract.
// a negative item ends after its first step and gives one error result.
// arst_n clears the controller and the output valid flag.
// a step waits while the output register holds a result not yet taken.
module decimal_digit_splitter #(
	parameter int MAX_DIGITS = dds_pkg::DEFAULT_MAX_DIGITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [dds_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,   // [3:0] digit, [7:4] position
	output logic                             m_tlast,
	output logic                             m_tuser    // [0] negative_error
);
	import dds_pkg::*;

	dds_cmd_t  cmd;
	dds_stat_t stat;

	logic [DIGIT_W-1:0] digit;
	logic [POS_W-1:0]   position;

	// sequencer
	dds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// digit unit and output register
	dds_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (s_tdata),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.digit          (digit),
		.position       (position),
		.last           (m_tlast),
		.negative_error (m_tuser)
	);

	assign m_tdata = {position, digit};

	// error result is a lone zero digit
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
		else $error("error item not a single zero digit");

	// no leading zero ahead of further digits
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:4] == 4'd0 && !m_tlast |-> m_tdata[3:0] != 4'd0)
		else $error("leading zero digit");

	// digits and positions stay within range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd9 && m_tdata[7:4] < 4'(NUM_POS)
			&& 32'(m_tdata[7:4]) < 32'(lim_of(MAX_DIGITS)))
		else $error("digit or position out of range");

	// no new item is taken while a digit run is in progress
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted during a run");

endmodule

`default_nettype wire

FILE: hw/rtl/dds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dds_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  var  dds_pkg::dds_stat_t stat,
	output dds_pkg::dds_cmd_t      cmd
);
	import dds_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;

	// take an item only when idle, step while the output slot is free
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_ready && in_valid;
		cmd.step = (state_q == ST_RUN) && stat.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cmd.step && stat.done)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dds_datapath #(
	parameter int MAX_DIGITS = dds_pkg::DEFAULT_MAX_DIGITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [dds_pkg::VALUE_W-1:0]  value,
	input  var  dds_pkg::dds_cmd_t            cmd,
	output dds_pkg::dds_stat_t                stat,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [dds_pkg::DIGIT_W-1:0]       digit,
	output logic [dds_pkg::POS_W-1:0]         position,
	output logic                              last,
	output logic                              negative_error
);
	import dds_pkg::*;

	localparam int LIM = lim_of(MAX_DIGITS);
	localparam logic [4:0] LIM_W = 5'(LIM);

	logic [VALUE_W-2:0] val_q;
	logic               neg_q;
	logic [POS_W-1:0]   pidx_q;
	logic               seen_q;
	logic [POS_W-1:0]   opos_q;

	logic               out_valid_q;
	logic [DIGIT_W-1:0] out_digit_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_last_q;
	logic               out_err_q;

	logic [THR_W-1:0] thr_tab [0:NUM_POS-1][1:9];
	logic [THR_W-1:0] thr [1:9];
	logic [THR_W-1:0] sub_val;
	logic [THR_W-1:0] rem;
	logic [DIGIT_W-1:0] dig;
	logic               emit;
	logic               in_range;

	// multiples of each power of ten, fixed at elaboration
	for (genvar gp = 0; gp < NUM_POS; gp++) begin : g_pos
		for (genvar gd = 1; gd <= 9; gd++) begin : g_dig
			assign thr_tab[gp][gd] = THR_W'(gd) * POW10[gp];
		end
	end

	// digit at the current position by parallel compare, then subtract
	always_comb begin
		dig = '0;
		sub_val = '0;
		for (int d = 1; d <= 9; d++) begin
			thr[d] = thr_tab[pidx_q][d];
			if ({{(THR_W-VALUE_W+1){1'b0}}, val_q} >= thr[d]) begin
				dig = DIGIT_W'(d);
				sub_val = thr[d];
			end
		end
		rem = {{(THR_W-VALUE_W+1){1'b0}}, val_q} - sub_val;
	end

	// positions above the limit and leading zeros are dropped
	always_comb begin
		in_range = ({1'b0, pidx_q} < LIM_W);
		emit = neg_q || (in_range && (dig != '0 || seen_q || pidx_q == '0));
	end

	always_comb begin
		stat.done = neg_q || (pidx_q == '0);
		stat.out_free = !out_valid_q || out_ready;
	end

	// working value and position counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value[VALUE_W-2:0];
			neg_q <= value[VALUE_W-1];
			pidx_q <= POS_W'(NUM_POS - 1);
			seen_q <= 1'b0;
			opos_q <= '0;
		end else if (cmd.step) begin
			val_q <= rem[VALUE_W-2:0];
			if (pidx_q != '0)
				pidx_q <= pidx_q - 1'b1;
			if (emit && !neg_q) begin
				seen_q <= 1'b1;
				opos_q <= opos_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.step && emit) begin
			out_digit_q <= neg_q ? '0 : dig;
			out_pos_q <= neg_q ? '0 : opos_q;
			out_last_q <= stat.done;
			out_err_q <= neg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign digit = out_digit_q;
	assign position = out_pos_q;
	assign last = out_last_q;
	assign negative_error = out_err_q;

endmodule

`default_nettype wire

FILE: tb/decimal_digit_splitter_tb.sv
`timescale 1ns / 1ps

module decimal_digit_splitter_tb;

	import dds_pkg::*;

	localparam int MAX_DIG = DEFAULT_MAX_DIGITS;
	localparam int DIGIT_LIMIT = (MAX_DIG < 1) ? 1 : ((MAX_DIG > 19) ? 19 : MAX_DIG);
	localparam int RESULT_CAP = 10;
	localparam int NUM_RANDOM = 360;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT_ITEM = 40;
	localparam int DRAIN_AT_ITEM = 200;
	localparam int TAIL_CYCLES = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_ROWS = 20;

	// one emitted digit
	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic [POS_W-1:0]   pos;
		logic               last;
		logic               neg_err;
	} digit_res_t;

	// directed stimulus row, typed rows carry a single known result
	typedef struct {
		logic [VALUE_W-1:0] value;
		bit                 typed;
		logic [DIGIT_W-1:0] digit;
		logic               neg_err;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [VALUE_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	digit_res_t digits_due[$];
	int mismatches = 0;
	int cycles = 0;
	logic hold_req = 1'b0;

	decimal_digit_splitter #(
		.MAX_DIGITS(MAX_DIG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// digits of one value, most significant first, queued as expected results
	function automatic void split_digits(input logic [VALUE_W-1:0] value);
		longint unsigned v;
		longint unsigned t;
		longint unsigned scale;
		int n;
		digit_res_t r;
		if (value[VALUE_W-1]) begin
			r = '{digit: 4'd0, pos: 4'd0, last: 1'b1, neg_err: 1'b1};
			digits_due.push_back(r);
			return;
		end
		// keep only the low digits the block can show
		scale = 1;
		for (int i = 0; i < DIGIT_LIMIT; i++)
			scale = scale * 10;
		v = longint'(value) % scale;
		n = 1;
		t = v;
		while (t >= 10) begin
			t = t / 10;
			n++;
		end
		if (n > RESULT_CAP)
			n = RESULT_CAP;
		for (int k = 0; k < n; k++) begin
			scale = 1;
			for (int i = 0; i < n - 1 - k; i++)
				scale = scale * 10;
			r.digit = DIGIT_W'((v / scale) % 10);
			r.pos = POS_W'(k);
			r.last = (k == n - 1);
			r.neg_err = 1'b0;
			digits_due.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// offer one item and hold it until taken, then queue what it should give
	task automatic offer_item(input logic [VALUE_W-1:0] v, input bit typed,
			input logic [DIGIT_W-1:0] digit, input logic neg_err);
		digit_res_t r;
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (typed) begin
			r = '{digit: digit, pos: 4'd0, last: 1'b1, neg_err: neg_err};
			digits_due.push_back(r);
		end else begin
			split_digits(v);
		end
	endtask

	// random value, mostly with an evenly spread digit count
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned sel;
		int unsigned n;
		longint unsigned lo;
		longint unsigned hi;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return {1'b1, 31'($urandom)};
		if (sel == 1)
			return $urandom;
		n = $urandom_range(1, 10);
		lo = 1;
		for (int i = 1; i < n; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (n == 1)
			lo = 0;
		if (hi > 64'h7FFF_FFFF)
			hi = 64'h7FFF_FFFF;
		return $urandom_range(32'(hi), 32'(lo));
	endfunction

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		digit_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digits_due.size() == 0) begin
				report_mismatch("unexpected item, digit", int'(m_tdata[3:0]), -1);
			end else begin
				want = digits_due.pop_front();
				if (m_tdata[3:0] !== want.digit)
					report_mismatch("digit", int'(m_tdata[3:0]), int'(want.digit));
				if (m_tdata[7:4] !== want.pos)
					report_mismatch("position", int'(m_tdata[7:4]), int'(want.pos));
				if (m_tlast !== want.last)
					report_mismatch("last", int'(m_tlast), int'(want.last));
				if (m_tuser !== want.neg_err)
					report_mismatch("negative_error", int'(m_tuser), int'(want.neg_err));
			end
		end
	end

	// receiver: phases of steady, random and periodic stalls, plus one long hold
	initial begin : receiver
		int mode;
		int len;
		bit hold_taken;
		hold_taken = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(10, 80);
			for (int i = 0; i < len; i++) begin
				@(posedge clk);
				if (hold_req && !hold_taken) begin
					hold_taken = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= (i % 5) < 3;
					endcase
				end
			end
		end
	end

	// sender
	initial begin : sender
		dir_row_t rows [NUM_ROWS];
		int burst_left;
		int gap;
		rows = '{
			'{32'd0,           1'b1, 4'd0, 1'b0},
			'{32'hFFFF_FFFF,   1'b1, 4'd0, 1'b1},
			'{32'h8000_0000,   1'b1, 4'd0, 1'b1},
			'{32'd1,           1'b1, 4'd1, 1'b0},
			'{32'd9,           1'b1, 4'd9, 1'b0},
			'{32'd10,          1'b0, 4'd0, 1'b0},
			'{32'd99,          1'b0, 4'd0, 1'b0},
			'{32'd100,         1'b0, 4'd0, 1'b0},
			'{32'h7FFF_FFFF,   1'b0, 4'd0, 1'b0},
			'{32'd1000000000,  1'b0, 4'd0, 1'b0},
			'{32'd999999999,   1'b0, 4'd0, 1'b0},
			'{32'd1234567890,  1'b0, 4'd0, 1'b0},
			'{32'd1999999999,  1'b0, 4'd0, 1'b0},
			'{32'd2000000000,  1'b0, 4'd0, 1'b0},
			'{32'h5555_5555,   1'b0, 4'd0, 1'b0},
			'{32'h2AAA_AAAA,   1'b0, 4'd0, 1'b0},
			'{32'd65536,       1'b0, 4'd0, 1'b0},
			'{32'hFFFF_FC18,   1'b1, 4'd0, 1'b1},
			'{32'd7,           1'b1, 4'd7, 1'b0},
			'{32'd1000,        1'b0, 4'd0, 1'b0}
		};
		burst_left = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i])
			offer_item(rows[i].value, rows[i].typed, rows[i].digit, rows[i].neg_err);

		// random items in bursts
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			if (i == HOLD_AT_ITEM)
				hold_req <= 1'b1;
			// let everything drain once before going on
			if (i == DRAIN_AT_ITEM && digits_due.size() != 0) begin
				s_tvalid <= 1'b0;
				while (digits_due.size() != 0)
					@(posedge clk);
			end
			offer_item(pick_value(), 1'b0, 4'd0, 1'b0);
		end

		s_tvalid <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/dds_pkg.sv
hw/rtl/dds_ctrl.sv
hw/rtl/dds_datapath.sv
hw/rtl/decimal_digit_splitter.sv
tb/decimal_digit_splitter_tb.sv
